@@ hw/rtl/ssl_pkg.sv @@
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the servo slew limiter
// Command codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

    localparam int unsigned COUNT_W = 10;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned CHAN_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned NUM_OUTPUTS = 6;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STEP_W-1:0]  t_step;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_POS = 2'd1,
        OP_SET_RAW = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_COUNT      = 2'd0,
        CFG_MAX_COUNT      = 2'd1,
        CFG_BASE_MAX_COUNT = 2'd2,
        CFG_SLEW_STEP      = 2'd3
    } t_cfg_idx;

    localparam t_count RST_MIN_COUNT      = 10'd50;
    localparam t_count RST_MAX_COUNT      = 10'd250;
    localparam t_count RST_BASE_MAX_COUNT = 10'd125;
    localparam t_step  RST_SLEW_STEP      = 8'd2;
    localparam t_count RST_COUNT          = 10'd150;

    localparam t_count PERCENT_MAX    = 10'd100;
    localparam t_count PERCENT_OFFSET = 10'd50;

endpackage

`default_nettype wire

@@ hw/rtl/servo_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// servo_slew_limiter: multi-channel servo pulse slew limiter
// Set commands load clamped per-channel targets; a tick moves every current
// pulse count toward its target by at most the slew step and reports them.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_opcode, i_channel, i_value
//  result    out        o_out_valid / i_out_ready  o_compare_ch0 .. o_compare_ch5
//  config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while o_in_ready is high; it is handled in
// the cycle it is accepted and a tick's result is shown from the next cycle on.
// The compare outputs are the current-count registers themselves, which only
// a tick changes, so o_in_ready is low only while a result is held unread.
// Reset (synchronous, active low) loads the register defaults and sets every
// target and current count to 150.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_limiter #(
    parameter int unsigned NUM_CHANNELS = 6
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ssl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [ssl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [1:0]                         i_opcode,
    input  wire [ssl_pkg::CHAN_W-1:0]         i_channel,
    input  wire [ssl_pkg::COUNT_W-1:0]        i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch0,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch1,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch2,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch3,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch4,
    output logic [ssl_pkg::COUNT_W-1:0]       o_compare_ch5
);

    ssl_pkg::t_count r_min_count;
    ssl_pkg::t_count r_max_count;
    ssl_pkg::t_count r_base_max_count;
    ssl_pkg::t_step  r_slew_step;

    ssl_pkg::t_count r_cur [NUM_CHANNELS];
    ssl_pkg::t_count r_tgt [NUM_CHANNELS];
    ssl_pkg::t_count n_cur [NUM_CHANNELS];
    ssl_pkg::t_count n_tgt [NUM_CHANNELS];

    logic            r_out_valid;
    logic            n_out_valid;
    logic            in_acc;
    logic            tick_acc;
    logic            set_acc;
    ssl_pkg::t_opcode op;
    ssl_pkg::t_count pct;
    ssl_pkg::t_count raw_tgt;
    ssl_pkg::t_count step_ext;
    ssl_pkg::t_count cmp [ssl_pkg::NUM_OUTPUTS];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count      <= ssl_pkg::RST_MIN_COUNT;
            r_max_count      <= ssl_pkg::RST_MAX_COUNT;
            r_base_max_count <= ssl_pkg::RST_BASE_MAX_COUNT;
            r_slew_step      <= ssl_pkg::RST_SLEW_STEP;
        end else if (i_cfg_we) begin
            unique case (ssl_pkg::t_cfg_idx'(i_cfg_idx))
                ssl_pkg::CFG_MIN_COUNT:      r_min_count      <= i_cfg_data;
                ssl_pkg::CFG_MAX_COUNT:      r_max_count      <= i_cfg_data;
                ssl_pkg::CFG_BASE_MAX_COUNT: r_base_max_count <= i_cfg_data;
                ssl_pkg::CFG_SLEW_STEP:      r_slew_step      <= i_cfg_data[ssl_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    always_comb begin
        op       = ssl_pkg::t_opcode'(i_opcode);
        in_acc   = i_in_valid && o_in_ready;
        tick_acc = 1'b0;
        set_acc  = 1'b0;
        unique case (op)
            ssl_pkg::OP_TICK:                        tick_acc = in_acc;
            ssl_pkg::OP_SET_POS, ssl_pkg::OP_SET_RAW: set_acc  = in_acc;
            default: ;
        endcase
        // Percent saturates at 100 and maps to 2*percent + 50 (at most 250).
        pct = (i_value > ssl_pkg::PERCENT_MAX) ? ssl_pkg::PERCENT_MAX : i_value;
        if (op == ssl_pkg::OP_SET_POS) begin
            raw_tgt = {pct[ssl_pkg::COUNT_W-2:0], 1'b0} + ssl_pkg::PERCENT_OFFSET;
        end else begin
            raw_tgt = i_value;
        end
        step_ext = ssl_pkg::COUNT_W'(r_slew_step);
    end

    // ------------------------------------------------------------------
    // Per-channel target clamp and slew
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
        ssl_pkg::t_count hi;
        ssl_pkg::t_count diff_up;
        ssl_pkg::t_count diff_dn;
        logic            sel;

        always_comb begin
            hi      = (k == 0) ? r_base_max_count : r_max_count;
            sel     = set_acc && (int'(i_channel) == k);
            diff_up = r_tgt[k] - r_cur[k];
            diff_dn = r_cur[k] - r_tgt[k];

            n_tgt[k] = r_tgt[k];
            if (sel) begin
                // The minimum test wins when the limits cross.
                if (raw_tgt < r_min_count) begin
                    n_tgt[k] = r_min_count;
                end else if (raw_tgt > hi) begin
                    n_tgt[k] = hi;
                end else begin
                    n_tgt[k] = raw_tgt;
                end
            end

            n_cur[k] = r_cur[k];
            if (tick_acc) begin
                if (r_tgt[k] > r_cur[k]) begin
                    n_cur[k] = (diff_up > step_ext) ? r_cur[k] + step_ext : r_tgt[k];
                end else if (r_cur[k] > r_tgt[k]) begin
                    n_cur[k] = (diff_dn > step_ext) ? r_cur[k] - step_ext : r_tgt[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cur[k] <= ssl_pkg::RST_COUNT;
                r_tgt[k] <= ssl_pkg::RST_COUNT;
            end else begin
                r_cur[k] <= n_cur[k];
                r_tgt[k] <= n_tgt[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result handshake
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid;
        if (tick_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Outputs of channels that do not exist read as zero.
    for (genvar j = 0; j < ssl_pkg::NUM_OUTPUTS; j++) begin : g_out
        if (j < NUM_CHANNELS) begin : g_used
            assign cmp[j] = r_cur[j];
        end else begin : g_unused
            assign cmp[j] = '0;
        end
    end

    assign o_compare_ch0 = cmp[0];
    assign o_compare_ch1 = cmp[1];
    assign o_compare_ch2 = cmp[2];
    assign o_compare_ch3 = cmp[3];
    assign o_compare_ch4 = cmp[4];
    assign o_compare_ch5 = cmp[5];

endmodule

`default_nettype wire

@@ hw/rtl/ssl_checker.sv @@
// ----------------------------------------------------------------------------
// ssl_checker: port-level checks of the servo slew limiter
// Watches the request and result channels and the compare outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           o_in_ready,
    input  wire [1:0]                     i_opcode,
    input  wire                           o_out_valid,
    input  wire                           i_out_ready,
    input  wire [ssl_pkg::COUNT_W-1:0]    o_compare_ch0,
    input  wire [ssl_pkg::COUNT_W-1:0]    o_compare_ch5
);

    logic tick_req;
    logic other_req;

    assign tick_req  = i_in_valid && o_in_ready
                       && (i_opcode == ssl_pkg::OP_TICK);
    assign other_req = i_in_valid && o_in_ready
                       && (i_opcode != ssl_pkg::OP_TICK);

    // An accepted tick always produces a result on the next cycle.
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_req |=> o_out_valid)
        else $error("accepted tick did not produce a result");

    // A set or unused command never produces a result of its own.
    a_set_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (other_req && (!o_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("non-tick request produced a result");

    // Compare values move only on an accepted tick.
    a_compare_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_req |=> ($stable(o_compare_ch0) && $stable(o_compare_ch5)))
        else $error("compare value changed without a tick");

    // A held result is not dropped or altered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_compare_ch0)))
        else $error("stalled result was lost or changed");

endmodule

bind servo_slew_limiter ssl_checker u_ssl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_compare_ch0 (o_compare_ch0),
    .o_compare_ch5 (o_compare_ch5)
);

`default_nettype wire

@@ tb/sv/servo_slew_limiter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_slew_limiter_tb: self-checking bench for the servo slew limiter
// Drives set-position, set-count, tick and ignored requests under several
// limit and step settings with random idling on both sides. A scoreboard
// keeps its own copy of the targets and current counts and compares every
// tick's compare values with its prediction.
// ----------------------------------------------------------------------------

module servo_slew_limiter_tb;

    localparam int unsigned SERVO_CHANNELS = 6;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned PHASES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 250;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        ssl_pkg::t_count cmp [ssl_pkg::NUM_OUTPUTS];
    } t_compare_set;

    class slew_scoreboard;
        ssl_pkg::t_count min_limit;
        ssl_pkg::t_count max_limit;
        ssl_pkg::t_count base_max_limit;
        ssl_pkg::t_step  step;
        ssl_pkg::t_count current_cnt [SERVO_CHANNELS];
        ssl_pkg::t_count target_cnt [SERVO_CHANNELS];
        t_compare_set expected_q [$];
        int unsigned errors;
        int unsigned reports;
        int unsigned requests_taken;
        int unsigned ticks_taken;
        int unsigned sets_checked;

        function new();
            min_limit      = ssl_pkg::RST_MIN_COUNT;
            max_limit      = ssl_pkg::RST_MAX_COUNT;
            base_max_limit = ssl_pkg::RST_BASE_MAX_COUNT;
            step           = ssl_pkg::RST_SLEW_STEP;
            for (int i = 0; i < SERVO_CHANNELS; i++) begin
                current_cnt[i] = ssl_pkg::RST_COUNT;
                target_cnt[i]  = ssl_pkg::RST_COUNT;
            end
            errors = 0;
            reports = 0;
            requests_taken = 0;
            ticks_taken = 0;
            sets_checked = 0;
        endfunction

        function void write_reg(ssl_pkg::t_cfg_idx idx, ssl_pkg::t_count data);
            case (idx)
                ssl_pkg::CFG_MIN_COUNT:      min_limit = data;
                ssl_pkg::CFG_MAX_COUNT:      max_limit = data;
                ssl_pkg::CFG_BASE_MAX_COUNT: base_max_limit = data;
                ssl_pkg::CFG_SLEW_STEP:      step = data[ssl_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // The minimum test wins when the limits cross.
        function ssl_pkg::t_count limit_target(int ch, int unsigned t);
            int unsigned hi;
            hi = (ch == 0) ? base_max_limit : max_limit;
            if (t < min_limit)
                return min_limit;
            if (t > hi)
                return ssl_pkg::t_count'(hi);
            return ssl_pkg::t_count'(t);
        endfunction

        function ssl_pkg::t_count slew_toward(ssl_pkg::t_count cur, ssl_pkg::t_count tgt);
            if (tgt > cur)
                return (tgt - cur > step) ? ssl_pkg::t_count'(cur + step) : tgt;
            if (cur > tgt)
                return (cur - tgt > step) ? ssl_pkg::t_count'(cur - step) : tgt;
            return cur;
        endfunction

        function void note_request(logic [1:0] opcode,
                                   logic [ssl_pkg::CHAN_W-1:0] channel,
                                   ssl_pkg::t_count value);
            t_compare_set res;
            int unsigned t;
            requests_taken++;
            if (opcode == ssl_pkg::OP_SET_POS || opcode == ssl_pkg::OP_SET_RAW) begin
                if (channel >= SERVO_CHANNELS)
                    return;
                if (opcode == ssl_pkg::OP_SET_POS)
                    t = ((value > ssl_pkg::PERCENT_MAX) ? ssl_pkg::PERCENT_MAX : value) * 2
                        + ssl_pkg::PERCENT_OFFSET;
                else
                    t = value;
                target_cnt[channel] = limit_target(channel, t);
            end else if (opcode == ssl_pkg::OP_TICK) begin
                ticks_taken++;
                for (int i = 0; i < SERVO_CHANNELS; i++)
                    current_cnt[i] = slew_toward(current_cnt[i], target_cnt[i]);
                for (int i = 0; i < ssl_pkg::NUM_OUTPUTS; i++)
                    res.cmp[i] = (i < SERVO_CHANNELS) ? current_cnt[i] : '0;
                expected_q.push_back(res);
            end
        endfunction

        function void check_compares(ssl_pkg::t_count actual [ssl_pkg::NUM_OUTPUTS]);
            t_compare_set exp_set;
            if (expected_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display("unexpected compare set at %0t", $time);
                reports++;
                return;
            end
            exp_set = expected_q.pop_front();
            sets_checked++;
            for (int i = 0; i < ssl_pkg::NUM_OUTPUTS; i++) begin
                if (actual[i] !== exp_set.cmp[i]) begin
                    errors++;
                    if (reports < MAX_REPORTS)
                        $display("compare_ch%0d mismatch at %0t: expected %0d, got %0d",
                                 i, $time, exp_set.cmp[i], actual[i]);
                    reports++;
                end
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ssl_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ssl_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [1:0]                     i_opcode;
    logic [ssl_pkg::CHAN_W-1:0]     i_channel;
    logic [ssl_pkg::COUNT_W-1:0]    i_value;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch0;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch1;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch2;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch3;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch4;
    logic [ssl_pkg::COUNT_W-1:0]    o_compare_ch5;

    slew_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_request;
    int unsigned settings_used;

    servo_slew_limiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_compare_ch0 (o_compare_ch0),
        .o_compare_ch1 (o_compare_ch1),
        .o_compare_ch2 (o_compare_ch2),
        .o_compare_ch3 (o_compare_ch3),
        .o_compare_ch4 (o_compare_ch4),
        .o_compare_ch5 (o_compare_ch5)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("servo_slew_limiter_tb NOT OK");
        $finish;
    end

    // Results are checked before the request taken at the same edge is noted.
    always @(posedge i_clk) begin
        ssl_pkg::t_count actual [ssl_pkg::NUM_OUTPUTS];
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                actual[0] = o_compare_ch0;
                actual[1] = o_compare_ch1;
                actual[2] = o_compare_ch2;
                actual[3] = o_compare_ch3;
                actual[4] = o_compare_ch4;
                actual[5] = o_compare_ch5;
                sb.check_compares(actual);
            end
            if (i_in_valid && o_in_ready)
                sb.note_request(i_opcode, i_channel, i_value);
        end
    end

    // Result side: random stalls, or a long hold-off when one is asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [ssl_pkg::CHAN_W-1:0] ch,
                                ssl_pkg::t_count val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_channel  <= ch;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned pick;
        int          near;
        logic [1:0]  op;
        logic [ssl_pkg::CHAN_W-1:0] ch;
        ssl_pkg::t_count val;
        pick = $urandom_range(99);
        ch   = ssl_pkg::CHAN_W'($urandom_range(SERVO_CHANNELS - 1));
        val  = ssl_pkg::COUNT_W'($urandom_range(1023));
        if (pick < 45) begin
            op = ssl_pkg::OP_TICK;
        end else if (pick < 65) begin
            op = ssl_pkg::OP_SET_POS;
            if ($urandom_range(9) < 7)
                val = ssl_pkg::COUNT_W'($urandom_range(110));
        end else if (pick < 85) begin
            op = ssl_pkg::OP_SET_RAW;
            // Half of the raw counts land right around one of the limits.
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(2))
                    0: near = sb.min_limit;
                    1: near = sb.max_limit;
                    default: near = sb.base_max_limit;
                endcase
                near = near + int'($urandom_range(6)) - 3;
                if (near < 0) near = 0;
                if (near > 1023) near = 1023;
                val = ssl_pkg::COUNT_W'(near);
            end
        end else if ($urandom_range(1) == 0) begin
            op = OP_UNUSED;
            ch = ssl_pkg::CHAN_W'($urandom_range(7));
        end else begin
            op = ($urandom_range(1) == 0) ? ssl_pkg::OP_SET_POS : ssl_pkg::OP_SET_RAW;
            ch = ssl_pkg::CHAN_W'($urandom_range(7, SERVO_CHANNELS));
        end
        send_request(op, ch, val);
    endtask

    // Waits first so the request taken at the last edge has been noted.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_limits(ssl_pkg::t_count lo, ssl_pkg::t_count hi,
                                ssl_pkg::t_count base_hi, ssl_pkg::t_step stp);
        ssl_pkg::t_count vals [4];
        vals[0] = lo;
        vals[1] = hi;
        vals[2] = base_hi;
        vals[3] = ssl_pkg::COUNT_W'(stp);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ssl_pkg::t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            sb.write_reg(ssl_pkg::t_cfg_idx'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b0;
        settings_used = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= ssl_pkg::CFG_MIN_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= ssl_pkg::OP_TICK;
        i_channel   <= '0;
        i_value     <= '0;
        i_out_ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset limits.
        send_request(ssl_pkg::OP_TICK, 3'd0, 10'd0);
        send_request(ssl_pkg::OP_SET_POS, 3'd1, 10'd0);
        send_request(ssl_pkg::OP_SET_POS, 3'd2, 10'd100);
        send_request(ssl_pkg::OP_SET_POS, 3'd3, 10'd101);
        send_request(ssl_pkg::OP_SET_POS, 3'd4, 10'd1023);
        send_request(ssl_pkg::OP_SET_RAW, 3'd5, 10'd0);
        send_request(ssl_pkg::OP_SET_RAW, 3'd5, 10'd1023);
        send_request(ssl_pkg::OP_SET_RAW, 3'd0, 10'd1023);
        send_request(ssl_pkg::OP_SET_POS, 3'd0, 10'd100);
        send_request(ssl_pkg::OP_SET_RAW, 3'd1, 10'd0);
        send_request(ssl_pkg::OP_SET_RAW, 3'd6, 10'd500);
        send_request(ssl_pkg::OP_SET_POS, 3'd7, 10'd50);
        send_request(OP_UNUSED, 3'd7, 10'd1023);
        send_request(ssl_pkg::OP_TICK, 3'd0, 10'd0);
        send_request(ssl_pkg::OP_TICK, 3'd5, 10'd0);
        send_request(ssl_pkg::OP_SET_RAW, 3'd3, 10'd682);
        send_request(ssl_pkg::OP_SET_RAW, 3'd4, 10'd341);
        repeat (5) send_request(ssl_pkg::OP_TICK, 3'd0, 10'd0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_limits(ssl_pkg::RST_MIN_COUNT, ssl_pkg::RST_MAX_COUNT,
                                ssl_pkg::RST_BASE_MAX_COUNT, ssl_pkg::RST_SLEW_STEP);
                1: apply_limits(10'd0, 10'd1023, 10'd1023, 8'd255);
                2: apply_limits(10'd1023, 10'd1023, 10'd1023, 8'd1);
                // Crossed limits and a step of zero.
                3: apply_limits(10'd300, 10'd200, 10'd100, 8'd0);
                4: apply_limits(10'd0, 10'd0, 10'd0, 8'd255);
                5: apply_limits(ssl_pkg::COUNT_W'($urandom_range(400)),
                                ssl_pkg::COUNT_W'($urandom_range(1023, 300)),
                                ssl_pkg::COUNT_W'($urandom_range(600, 100)),
                                ssl_pkg::STEP_W'($urandom_range(255, 1)));
                6: apply_limits(ssl_pkg::COUNT_W'($urandom_range(1023)),
                                ssl_pkg::COUNT_W'($urandom_range(1023)),
                                ssl_pkg::COUNT_W'($urandom_range(1023)),
                                ssl_pkg::STEP_W'($urandom_range(255)));
                default: apply_limits(10'd100, 10'd900, 10'd500, 8'd17);
            endcase
            if (ph < 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 76;
            end else if (ph < 6) begin
                send_idle_pct = 76;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 1 && n == 100) begin
                    // Keep ticking into a stalled result side so the request
                    // side backs up.
                    hold_request = 1'b1;
                    repeat (30) send_request(ssl_pkg::OP_TICK, 3'd0, 10'd0);
                end
                if (ph == 4 && n == 120)
                    wait_idle();
                send_random();
            end
            wait_idle();
        end

        $display("%0d requests taken, %0d of them ticks; %0d compare sets checked",
                 sb.requests_taken, sb.ticks_taken, sb.sets_checked);
        $display("%0d limit settings applied, including crossed limits and zero step",
                 settings_used);
        if (sb.expected_q.size() != 0)
            sb.errors++;
        if (sb.errors == 0) begin
            $display("servo_slew_limiter_tb OK");
        end else begin
            $display("%0d errors", sb.errors);
            $display("servo_slew_limiter_tb NOT OK");
        end
        $finish;
    end

endmodule
